### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: concurrent assertion macros
// Both sample on clk; the first one is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLKD(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### design/bgpd_pkg.sv
// ---------------------------------------------------------------------------
// bgpd_pkg: shared types and constants
// Field widths, header offsets, result codes and controller/datapath structs.
// ---------------------------------------------------------------------------
package bgpd_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int COORD_W   = 12;
  localparam int PADDED_W  = DIM_W + 2;
  localparam int PROD_W    = PADDED_W + DIM_W;

  localparam logic [31:0] HDR_LAST_OFF   = 32'd29;
  localparam logic [31:0] MIN_DATA_START = 32'd54;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;

  // floor(x/3) for x <= 765: x * 683 >> 11
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_SIZE   = 2'd1,
    KIND_HEADER = 2'd2
  } kind_t;

  typedef struct packed {
    logic clear;     // start of a new file
    logic hdr;       // header byte
    logic skip;      // byte before the pixel data, or the first data byte (offset counted)
    logic pix;       // pixel data byte
    logic pad;       // row padding byte
    logic chk_a;     // header check: ranges and row size
    logic chk_b;     // header check: padded row times height
    logic emit_err;  // post the error result
  } cmd_t;

  typedef struct packed {
    logic off_last_hdr;
    logic at_start;
    logic bip_last;
    logic bip_is2;
    logic row_end;
    logic final_px;
    logic pad_nz;
    logic pad_last;
    logic hdr_bad;
    logic size_bad;
    logic out_busy;
  } stat_t;

  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] prod;
    prod = s * DIV3_MUL;
    return prod[DIV3_SHIFT +: 8];
  endfunction

endpackage

### design/bgpd_if.sv
// ---------------------------------------------------------------------------
// bgpd channel interfaces
// Byte request channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface bgpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

interface bgpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] row;
  logic [11:0] col;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  gray;
  logic        last;

  modport source (output valid, output kind, output row, output col, output red,
                  output green, output blue, output gray, output last, input ready);
  modport sink   (input valid, input kind, input row, input col, input red,
                  input green, input blue, input gray, input last, output ready);
endinterface

### design/bgpd_datapath.sv
// ---------------------------------------------------------------------------
// bgpd_datapath: header fields, counters, header check and result register
// Executes the controller's commands one request at a time.
// ---------------------------------------------------------------------------
module bgpd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  bgpd_pkg::cmd_t    cmd,
  output bgpd_pkg::stat_t   st,
  input  logic [7:0]        file_byte,
  bgpd_out_if.source        out_if
);

  logic [31:0] offset_r;
  logic [31:0] size_r;
  logic [31:0] start_r;
  logic [31:0] width_r;
  logic [31:0] height_r;
  logic [15:0] bpp_r;
  logic        bpp32_r;
  logic [1:0]  pad_r;
  logic [bgpd_pkg::PADDED_W-1:0] padded_r;
  logic [bgpd_pkg::PROD_W-1:0]   prod_r;
  logic        hdr_bad_r;
  logic [bgpd_pkg::DIM_W-1:0] col_r;
  logic [bgpd_pkg::DIM_W-1:0] rows_r;
  logic [1:0]  bip_r;
  logic [7:0]  blue_r;
  logic [7:0]  green_r;
  logic [1:0]  pad_left_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [11:0] out_row_r;
  logic [11:0] out_col_r;
  logic [7:0]  out_red_r;
  logic [7:0]  out_green_r;
  logic [7:0]  out_blue_r;
  logic [7:0]  out_gray_r;
  logic        out_last_r;

  logic [bgpd_pkg::DIM_W-1:0]    width_d;
  logic [bgpd_pkg::DIM_W-1:0]    height_d;
  logic                          is_bpp32;
  logic [bgpd_pkg::PADDED_W-1:0] row_bytes;
  logic [1:0]                    pad_calc;
  logic                          hdr_bad;
  logic [32:0]                   total;
  logic [1:0]                    lane_a;
  logic [9:0]                    pix_sum;
  logic [bgpd_pkg::DIM_W-1:0]    row_td;

  assign width_d  = width_r[bgpd_pkg::DIM_W-1:0];
  assign height_d = height_r[bgpd_pkg::DIM_W-1:0];
  assign is_bpp32 = (bpp_r == bgpd_pkg::BPP_32);

  always_comb begin
    if (is_bpp32) begin
      row_bytes = {width_d, 2'b00};
    end else begin
      row_bytes = {1'b0, width_d, 1'b0} + {2'b00, width_d};
    end
    pad_calc = 2'd0 - row_bytes[1:0];
  end

  assign hdr_bad = !((bpp_r == bgpd_pkg::BPP_24) || is_bpp32) ||
                   (width_r == 32'd0) || (width_r > 32'(bgpd_pkg::MAX_DIM)) ||
                   (height_r == 32'd0) || (height_r > 32'(bgpd_pkg::MAX_DIM)) ||
                   (start_r < bgpd_pkg::MIN_DATA_START);

  assign total  = {1'b0, start_r} + 33'(prod_r);
  // field byte lane; data start, width and height sit at the same alignment as size
  assign lane_a = offset_r[1:0] - 2'd2;

  assign pix_sum = {2'b00, file_byte} + {2'b00, green_r} + {2'b00, blue_r};
  assign row_td  = height_d - bgpd_pkg::DIM_W'(1) - rows_r;

  always_comb begin
    st.off_last_hdr = (offset_r == bgpd_pkg::HDR_LAST_OFF);
    st.at_start     = (offset_r == start_r);
    st.bip_last     = (bip_r == (bpp32_r ? 2'd3 : 2'd2));
    st.bip_is2      = (bip_r == 2'd2);
    st.row_end      = ((col_r + bgpd_pkg::DIM_W'(1)) == width_d);
    st.final_px     = st.row_end && ((rows_r + bgpd_pkg::DIM_W'(1)) == height_d);
    st.pad_nz       = (pad_r != 2'd0);
    st.pad_last     = (pad_left_r == 2'd1);
    st.hdr_bad      = hdr_bad_r;
    st.size_bad     = (total != {1'b0, size_r});
    st.out_busy     = out_valid_r && !out_if.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      offset_r   <= 32'd1;
      size_r     <= '0;
      start_r    <= '0;
      width_r    <= '0;
      height_r   <= '0;
      bpp_r      <= '0;
      col_r      <= '0;
      rows_r     <= '0;
      bip_r      <= '0;
      pad_left_r <= '0;
    end
    if (cmd.hdr) begin
      offset_r <= offset_r + 32'd1;
      case (offset_r) inside
        [32'd2:32'd5]:   size_r[{lane_a, 3'b000} +: 8]   <= file_byte;
        [32'd10:32'd13]: start_r[{lane_a, 3'b000} +: 8]  <= file_byte;
        [32'd18:32'd21]: width_r[{lane_a, 3'b000} +: 8]  <= file_byte;
        [32'd22:32'd25]: height_r[{lane_a, 3'b000} +: 8] <= file_byte;
        [32'd28:32'd29]: bpp_r[{offset_r[0], 3'b000} +: 8] <= file_byte;
        default: ;
      endcase
    end
    if (cmd.skip) begin
      offset_r <= offset_r + 32'd1;
    end
    if (cmd.chk_a) begin
      hdr_bad_r <= hdr_bad;
      bpp32_r   <= is_bpp32;
      pad_r     <= pad_calc;
      padded_r  <= row_bytes + bgpd_pkg::PADDED_W'(pad_calc);
    end
    if (cmd.chk_b) begin
      prod_r <= padded_r * bgpd_pkg::PROD_W'(height_d);
    end
    if (cmd.pix) begin
      case (bip_r)
        2'd0:    blue_r  <= file_byte;
        2'd1:    green_r <= file_byte;
        default: ;
      endcase
      if (!(st.bip_is2 && st.final_px)) begin
        if (st.bip_last) begin
          bip_r <= '0;
          if (st.row_end) begin
            col_r  <= '0;
            rows_r <= rows_r + bgpd_pkg::DIM_W'(1);
            if (st.pad_nz) begin
              pad_left_r <= pad_r;
            end
          end else begin
            col_r <= col_r + bgpd_pkg::DIM_W'(1);
          end
        end else begin
          bip_r <= bip_r + 2'd1;
        end
      end
    end
    if (cmd.pad) begin
      pad_left_r <= pad_left_r - 2'd1;
    end

    // result register
    if (cmd.pix && st.bip_is2) begin
      out_kind_r  <= bgpd_pkg::KIND_PIXEL;
      out_row_r   <= row_td[bgpd_pkg::COORD_W-1:0];
      out_col_r   <= bgpd_pkg::COORD_W'(col_r);
      out_red_r   <= file_byte;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_gray_r  <= bgpd_pkg::div3(pix_sum);
      out_last_r  <= st.final_px;
    end else if (cmd.emit_err) begin
      out_kind_r  <= hdr_bad_r ? bgpd_pkg::KIND_HEADER : bgpd_pkg::KIND_SIZE;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_red_r   <= '0;
      out_green_r <= '0;
      out_blue_r  <= '0;
      out_gray_r  <= '0;
      out_last_r  <= 1'b1;
    end

    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.pix && st.bip_is2) || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.kind  = out_kind_r;
  assign out_if.row   = out_row_r;
  assign out_if.col   = out_col_r;
  assign out_if.red   = out_red_r;
  assign out_if.green = out_green_r;
  assign out_if.blue  = out_blue_r;
  assign out_if.gray  = out_gray_r;
  assign out_if.last  = out_last_r;

endmodule

### design/bgpd_ctrl.sv
// ---------------------------------------------------------------------------
// bgpd_ctrl: parse controller
// Tracks the file phase, drives input ready and issues datapath commands.
// ---------------------------------------------------------------------------
module bgpd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  bgpd_in_if.sink         in_if,
  input  bgpd_pkg::stat_t st,
  output bgpd_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEADER,
    S_CHK_A,
    S_CHK_B,
    S_CHK_C,
    S_SKIP,
    S_PIXEL,
    S_PAD,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   open;
  logic   acc;

  always_comb begin
    open = !((state_r == S_CHK_A) || (state_r == S_CHK_B) || (state_r == S_CHK_C));
    in_if.ready = rst_n && open && !st.out_busy;
    acc = in_if.valid && in_if.ready;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CHK_A: begin
        cmd.chk_a = 1'b1;
        state_nxt = S_CHK_B;
      end
      S_CHK_B: begin
        cmd.chk_b = 1'b1;
        state_nxt = S_CHK_C;
      end
      S_CHK_C: begin
        if (!st.out_busy) begin
          if (st.hdr_bad || st.size_bad) begin
            cmd.emit_err = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SKIP;
          end
        end
      end
      default: begin
        if (acc && in_if.first_byte) begin
          cmd.clear = 1'b1;
          state_nxt = S_HEADER;
        end else if (acc) begin
          case (state_r)
            S_HEADER: begin
              cmd.hdr = 1'b1;
              if (st.off_last_hdr) begin
                state_nxt = S_CHK_A;
              end
            end
            S_SKIP: begin
              cmd.skip = 1'b1;
              if (st.at_start) begin
                cmd.pix   = 1'b1;
                state_nxt = S_PIXEL;
              end
            end
            S_PIXEL: begin
              cmd.pix = 1'b1;
            end
            S_PAD: begin
              cmd.pad = 1'b1;
              if (st.pad_last) begin
                state_nxt = S_PIXEL;
              end
            end
            default: ;
          endcase
          // pixel byte outcome, also for the first data byte taken in skip
          if (cmd.pix) begin
            if (st.bip_is2 && st.final_px) begin
              state_nxt = S_DONE;
            end else if (st.bip_last && st.row_end && st.pad_nz) begin
              state_nxt = S_PAD;
            end
          end
        end
      end
    endcase
    if (!rst_n) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/bmp_gray_pixel_decoder_top.sv
// ---------------------------------------------------------------------------
// bmp_gray_pixel_decoder_top: BMP byte stream to gray pixel results
// Parses the BMP header, checks it and emits one result per pixel or one error result.
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : one file byte per request; first_byte marks offset 0 of a file
//            and restarts parsing whenever it is taken.
//   out_if : one result per pixel (kind pixel, top-down row, column, RGB,
//            gray) or one error result (size mismatch / bad header), last set
//            on the final pixel and on errors.
// Throughput: one byte per cycle unless a result is stalled; after header
//   byte 29 input ready is low while the header check runs (range checks,
//   padded row times height multiply, size compare).
// Latency: a pixel result is valid the cycle after its red byte is taken;
//   an error result is registered from S_CHK_C, after S_CHK_A and S_CHK_B.
// Reset: synchronous, active low; the block waits for a first byte.
// Stall: results sit in a single output register; while it holds a result
//   that the receiver does not take, input ready is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_gray_pixel_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  bgpd_in_if.sink     in_if,
  bgpd_out_if.source  out_if
);

  bgpd_pkg::cmd_t  cmd;
  bgpd_pkg::stat_t st;

  logic pix_post;
  logic out_pix;
  logic out_err;

  bgpd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .st    (st),
    .cmd   (cmd)
  );

  bgpd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .file_byte (in_if.file_byte),
    .out_if    (out_if)
  );

  assign pix_post = cmd.pix && st.bip_is2;
  assign out_pix  = out_if.valid && (out_if.kind == bgpd_pkg::KIND_PIXEL);
  assign out_err  = out_if.valid && out_if.last && (out_if.kind != bgpd_pkg::KIND_PIXEL);

  `ASSERT_CLKD(a_stall_blocks_input, (out_if.valid && !out_if.ready) |-> !in_if.ready)
  `ASSERT_CLKD(a_red_byte_posts_pixel, pix_post |=> out_pix)
  `ASSERT_CLKD(a_error_is_last, cmd.emit_err |=> out_err)

endmodule
